/* rtl/core/mrw_pkg.sv */
// Package for the Miller-Rabin witness test block.
// Holds the width defaults and the verdict codes. No dependencies.
package mrw_pkg;

  // Width of the input fields on the ports.
  localparam int unsigned FieldWidth    = 32;
  // Default width of the arithmetic (low bits of each field that are used).
  localparam int unsigned NumWidthDef   = 32;
  localparam int unsigned VerdictWidth  = 2;

  localparam logic [VerdictWidth-1:0] VerdictComposite = 2'd0;
  localparam logic [VerdictWidth-1:0] VerdictPrime     = 2'd1;
  localparam logic [VerdictWidth-1:0] VerdictInvalid   = 2'd2;

endpackage

/* rtl/core/miller_rabin_witness_test.sv */
// Miller-Rabin witness test, top level: input handshake and output register.
// Depends on mrw_pkg, mrw_seq (which holds mrw_modmul).
//
// Usage:
//   Present candidate_i (n) and witness_base_i (a) with in_valid_i; the item
//   is taken when in_valid_i and in_ready_o are both high. One verdict item
//   per input item leaves on verdict_o with out_valid_o / out_ready_i:
//   0 composite, 1 probable prime for this base, 2 candidate below two.
//   Only the low NUM_WIDTH bits of each field are used.
// Cost: every modular product runs on the single shared multiply-and-reduce
//   unit. An item needs one base reduction and at most 2*NUM_WIDTH-1 further
//   products between square-and-multiply and the squaring chain together; a
//   candidate below two needs no product.
// Throughput: one item at a time; in_ready_o is low while an item is at work.
//   A new item may be taken while the previous verdict waits at the output.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// Stall: when out_ready_i is low the verdict holds in the output register and
//   a following verdict holds in the sequencer until the register frees.
module miller_rabin_witness_test import mrw_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FieldWidth-1:0]   candidate_i,
  input  logic [FieldWidth-1:0]   witness_base_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VerdictWidth-1:0] verdict_o
);

  logic                    seq_idle, seq_fin, fin_ready;
  logic [VerdictWidth-1:0] seq_verdict;
  logic                    out_valid_q;
  logic [VerdictWidth-1:0] verdict_q;

  // free the output slot when empty or being drained this cycle
  assign fin_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = seq_idle;

  mrw_seq #(.NUM_WIDTH(NUM_WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && seq_idle),
    .cand_i      (candidate_i[NUM_WIDTH-1:0]),
    .base_i      (witness_base_i[NUM_WIDTH-1:0]),
    .fin_ready_i (fin_ready),
    .idle_o      (seq_idle),
    .fin_valid_o (seq_fin),
    .verdict_o   (seq_verdict)
  );

  // output register: load a finished verdict, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready) begin
      out_valid_q <= seq_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready && seq_fin) begin
      verdict_q <= seq_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

/* rtl/core/mrw_modmul.sv */
// Shared modular multiplier: (op_a * op_b) mod modulus.
// The product is registered first, then one restoring reduction step per bit.
// Depends on mrw_pkg.
module mrw_modmul import mrw_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] op_a_i,
  input  logic [NUM_WIDTH-1:0] op_b_i,
  input  logic [NUM_WIDTH-1:0] mod_i,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] res_o
);

  localparam int unsigned PW = 2 * NUM_WIDTH;
  localparam int unsigned CW = $clog2(PW);

  logic [PW-1:0]        prod_q;
  logic [NUM_WIDTH:0]   rem_q, rem_d, trial;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic                 ge;

  // Bring down the next product bit; remainder stays below twice the modulus.
  assign trial = {rem_q[NUM_WIDTH-1:0], prod_q[PW-1]};
  assign ge    = trial >= {1'b0, mod_i};
  assign rem_d = ge ? (trial - {1'b0, mod_i}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(PW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= {{NUM_WIDTH{1'b0}}, op_a_i} * {{NUM_WIDTH{1'b0}}, op_b_i};
      rem_q  <= '0;
    end else if (busy_q) begin
      prod_q <= prod_q << 1;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = rem_q[NUM_WIDTH-1:0];

endmodule

/* rtl/core/mrw_seq.sv */
// Miller-Rabin round sequencer: splits n-1 if n is odd, runs square-and-multiply
// and the squaring chain on the shared mrw_modmul. Depends on mrw_pkg, mrw_modmul.
module mrw_seq import mrw_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUM_WIDTH-1:0]    cand_i,
  input  logic [NUM_WIDTH-1:0]    base_i,
  input  logic                    fin_ready_i,
  output logic                    idle_o,
  output logic                    fin_valid_o,
  output logic [VerdictWidth-1:0] verdict_o
);

  localparam int unsigned KW = $clog2(NUM_WIDTH + 1);
  localparam logic [NUM_WIDTH-1:0] One = NUM_WIDTH'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHK   = 10'b00_0000_0010,
    S_RED   = 10'b00_0000_0100,
    S_SPLIT = 10'b00_0000_1000,
    S_POW   = 10'b00_0001_0000,
    S_MULA  = 10'b00_0010_0000,
    S_MULS  = 10'b00_0100_0000,
    S_TST   = 10'b00_1000_0000,
    S_SQ    = 10'b01_0000_0000,
    S_SQW   = 10'b10_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [KW-1:0]           k_q, k_d, cnt_q, cnt_d;
  logic [VerdictWidth-1:0] verdict_q, verdict_d;
  logic                    fin_q, fin_d;
  logic [NUM_WIDTH-1:0]    n_q, n_d, sq_q, sq_d, acc_q, acc_d, exp_q, exp_d;
  logic [NUM_WIDTH-1:0]    n_m1;
  logic                    mm_start, mm_done;
  logic [NUM_WIDTH-1:0]    mm_a, mm_b, mm_res;

  assign n_m1 = n_q - One;

  mrw_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .op_a_i  (mm_a),
    .op_b_i  (mm_b),
    .mod_i   (n_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    verdict_d = verdict_q;
    fin_d     = fin_q;
    n_d       = n_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    exp_d     = exp_q;
    mm_start  = 1'b0;
    mm_a      = sq_q;
    mm_b      = sq_q;
    unique case (state_q)
      S_IDLE: begin
        if (fin_q) begin
          if (fin_ready_i) fin_d = 1'b0;
        end else if (start_i) begin
          n_d     = cand_i;
          sq_d    = base_i;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        exp_d = n_m1;
        k_d   = '0;
        if (n_q < NUM_WIDTH'(2)) begin
          verdict_d = VerdictInvalid;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end else begin
          // reduce the base: base * 1 mod n
          mm_start = 1'b1;
          mm_b     = One;
          state_d  = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) begin
          sq_d    = mm_res;
          acc_d   = One;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // strip trailing zeros of n-1 for odd n only
        if (n_q[0] && !exp_q[0]) begin
          exp_d = exp_q >> 1;
          k_d   = k_q + 1'b1;
        end else begin
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (exp_q == '0) begin
          state_d = S_TST;
        end else if (exp_q[0]) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          state_d  = S_MULA;
        end else begin
          mm_start = 1'b1;
          state_d  = S_MULS;
        end
      end
      S_MULA: begin
        if (mm_done) begin
          acc_d    = mm_res;
          mm_start = 1'b1;
          state_d  = S_MULS;
        end
      end
      S_MULS: begin
        if (mm_done) begin
          sq_d    = mm_res;
          exp_d   = exp_q >> 1;
          state_d = S_POW;
        end
      end
      S_TST: begin
        cnt_d = k_q;
        if (acc_q == One || acc_q == n_m1) begin
          verdict_d = VerdictPrime;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (cnt_q <= KW'(1)) begin
          verdict_d = VerdictComposite;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end else begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          mm_b     = acc_q;
          state_d  = S_SQW;
        end
      end
      S_SQW: begin
        if (mm_done) begin
          acc_d = mm_res;
          cnt_d = cnt_q - 1'b1;
          if (mm_res == One) begin
            verdict_d = VerdictComposite;
            fin_d     = 1'b1;
            state_d   = S_IDLE;
          end else if (mm_res == n_m1) begin
            verdict_d = VerdictPrime;
            fin_d     = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_SQ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    n_q       <= n_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    exp_q     <= exp_d;
  end

  // a finished verdict is held until the output stage takes it
  assign idle_o      = (state_q == S_IDLE) && !fin_q;
  assign fin_valid_o = fin_q;
  assign verdict_o   = verdict_q;

endmodule
